[rtl/pli_pkg.sv]
package pli_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 4;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 4'd0,
        OP_INS_TAIL = 4'd1,
        OP_INS_AT   = 4'd2,
        OP_DEL_HEAD = 4'd3,
        OP_DEL_TAIL = 4'd4,
        OP_DEL_AT   = 4'd5,
        OP_GET_HEAD = 4'd6,
        OP_GET_TAIL = 4'd7,
        OP_GET_AT   = 4'd8
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [IDX_W-1:0]        at;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

[rtl/positional_list_insert_delete.sv]
// Bounded ordered list of up to CAPACITY signed 32-bit values, held in a row
// of cells, one entry per cell. Each input beat carries an opcode, a position
// and a value; every input beat yields exactly one output beat with the value
// read, a status code and the element count after the operation. Inserts and
// deletes shift all entries behind the chosen position by one cell, all cells
// moving together. The result of an accepted beat is registered as the beat is
// taken and presented on the output, and a new input beat is taken every
// cycle as long as the output side does not stall.
// Errors (empty list, bad position, full list) leave the list untouched.
// The input channel stalls only while a result is waiting and the output
// channel is stalled. No clearing pass is needed after reset.
module positional_list_insert_delete
    import pli_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    // Output channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [ST_W-1:0]         o_status,
    output logic [CNT_W-1:0]        o_count
);

    // Element count and the registered result beat.
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_read_value;
    logic [ST_W-1:0]         r_status;
    logic [CNT_W-1:0]        r_out_count;

    logic                    accept;
    logic                    ins;
    logic                    del;
    logic [CMP_W-1:0]        at_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        pos_ext;
    logic signed [VAL_W-1:0] rd;
    t_status                 st;
    t_cell_cmd               cmd;
    logic signed [VAL_W-1:0] cell_val [CAPACITY];

    // A new beat may enter whenever the output register is empty or is being
    // drained in this same cycle.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign cnt_ext = CMP_W'(r_count);
    assign pos_ext = CMP_W'(i_position);

    // Operation decode: pick the target position and check it against the
    // current count. Positional inserts are range checked before the full
    // check, and reads and deletes see the empty check first.
    always_comb begin
        ins    = 1'b0;
        del    = 1'b0;
        rd     = '0;
        st     = ST_OK;
        at_ext = '0;
        case (i_opcode)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (i_opcode == OP_INS_HEAD) begin
                    at_ext = '0;
                end else if (i_opcode == OP_INS_TAIL) begin
                    at_ext = cnt_ext;
                end else begin
                    at_ext = pos_ext;
                end
                if (at_ext > cnt_ext) begin
                    st = ST_BADPOS;
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    st = ST_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT,
            OP_GET_HEAD, OP_GET_TAIL, OP_GET_AT: begin
                if (i_opcode == OP_DEL_HEAD || i_opcode == OP_GET_HEAD) begin
                    at_ext = '0;
                end else if (i_opcode == OP_DEL_TAIL || i_opcode == OP_GET_TAIL) begin
                    at_ext = cnt_ext - CMP_W'(1);
                end else begin
                    at_ext = pos_ext;
                end
                if (r_count == '0) begin
                    st = ST_EMPTY;
                end else if (at_ext >= cnt_ext) begin
                    st = ST_BADPOS;
                end else if (i_opcode == OP_GET_HEAD || i_opcode == OP_GET_TAIL ||
                             i_opcode == OP_GET_AT) begin
                    // The position is below the count here, so it fits the
                    // cell index.
                    rd = cell_val[at_ext[IDX_W-1:0]];
                end else begin
                    del = 1'b1;
                end
            end
            default: begin
                // Unused opcodes do nothing and report success.
            end
        endcase
    end

    // The shift command only fires on an accepted beat.
    assign cmd.ins   = accept & ins;
    assign cmd.del   = accept & del;
    assign cmd.at    = at_ext[IDX_W-1:0];
    assign cmd.value = i_value;

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // The chain: cell zero takes the inserted value from the command, and the
    // last cell feeds back its own value on delete since nothing lies behind.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = i_value;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_val[g];
        end else begin : g_mid_r
            assign right = cell_val[g+1];
        end

        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_index (IDX_W'(g)),
            .i_left  (left),
            .i_right (right),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= rd;
            r_status     <= st;
            r_out_count  <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_out_count;

endmodule

[rtl/pli_cell.sv]
module pli_cell
    import pli_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_value
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    // On insert the cell at the gap takes the new value and the cells behind
    // it take their left neighbor; on delete every cell from the gap on takes
    // its right neighbor.
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_index > i_cmd.at) begin
                n_value = i_left;
            end else if (i_index == i_cmd.at) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (i_index >= i_cmd.at) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
